/* sv/ksmx_pkg.sv */
package ksmx_pkg;

    localparam int KEY_W  = 32;
    localparam int MARK_W = 4;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [MARK_W-1:0] MARK_MAX = 4'd10;

    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_HIGHEST = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOWEST  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic hit;
        logic scan_end;
    } ctl_sts_t;

endpackage

/* sv/keyed_slot_table_min_max_extract_unit.sv */
// Channel   Handshake                 Signals
// command   start & !busy             func, entry_key, entry_mark
// result    done strobe, one cycle    status, out_key, out_mark, out_slot
// config    cfg_valid & cfg_ready     cfg_data (slots_in_use)
//
// Scan, compare and insert share one slot memory port pair, one slot per cycle.
// Insert, remove and extract step through accept, one read per slot up to slots_in_use,
// the read return, an end check and finish; a key or free-slot hit ends the scan
// early. Clear and unused codes go from accept straight to finish.
// done is high in the first idle cycle, once per command; the receiver cannot stall it.
// Reset empties the table at once and sets slots_in_use to 16; no clearing pass.
module keyed_slot_table_min_max_extract_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ksmx_pkg::FUNC_W-1:0]         func,
    input  logic [ksmx_pkg::KEY_W-1:0]          entry_key,
    input  logic [ksmx_pkg::MARK_W-1:0]         entry_mark,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ksmx_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [ksmx_pkg::STAT_W-1:0]         status,
    output logic [ksmx_pkg::KEY_W-1:0]          out_key,
    output logic [ksmx_pkg::MARK_W-1:0]         out_mark,
    output logic [ksmx_pkg::SLOT_W-1:0]         out_slot
);

    ksmx_pkg::ctl_cmd_t cmd;
    ksmx_pkg::ctl_sts_t sts;

    ksmx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ksmx_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (func),
        .entry_key  (entry_key),
        .entry_mark (entry_mark),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .out_key    (out_key),
        .out_mark   (out_mark),
        .out_slot   (out_slot)
    );

    // a result only follows a command in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in progress");

    // accepted command keeps the unit busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    // failed operations report zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ksmx_pkg::ST_FULL || status == ksmx_pkg::ST_NONE))
        |-> (out_key == '0 && out_mark == '0 && out_slot == '0))
        else $error("failed operation with non-zero payload");

    // no result back to back
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

endmodule

/* sv/ksmx_ram.sv */
module ksmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ksmx_ctrl.sv */
module ksmx_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ksmx_pkg::ctl_sts_t  sts,
    output ksmx_pkg::ctl_cmd_t  cmd,
    output logic                busy
);

    ksmx_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksmx_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ksmx_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.needs_scan ? ksmx_pkg::S_SCAN : ksmx_pkg::S_DONE;
                end
            end
            ksmx_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.scan_end)
                begin
                    state_next = ksmx_pkg::S_DONE;
                end
            end
            ksmx_pkg::S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ksmx_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ksmx_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/ksmx_dp.sv */
module ksmx_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ksmx_pkg::ctl_cmd_t                  cmd,
    output ksmx_pkg::ctl_sts_t                  sts,
    input  logic [ksmx_pkg::FUNC_W-1:0]         func,
    input  logic [ksmx_pkg::KEY_W-1:0]          entry_key,
    input  logic [ksmx_pkg::MARK_W-1:0]         entry_mark,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ksmx_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [ksmx_pkg::STAT_W-1:0]         status,
    output logic [ksmx_pkg::KEY_W-1:0]          out_key,
    output logic [ksmx_pkg::MARK_W-1:0]         out_mark,
    output logic [ksmx_pkg::SLOT_W-1:0]         out_slot
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = ksmx_pkg::KEY_W + ksmx_pkg::MARK_W;

    // control state
    logic [ksmx_pkg::CFG_W-1:0]  cfg_reg, cfg_next;
    logic [DEPTH-1:0]            valid_reg, valid_next;
    logic [CW-1:0]               addr_reg, addr_next;
    logic [CW-1:0]               n_reg, n_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic                        found_reg, found_next;
    logic                        done_reg, done_next;

    // payload
    logic [ksmx_pkg::FUNC_W-1:0] op_reg, op_next;
    logic [ksmx_pkg::KEY_W-1:0]  op_key_reg, op_key_next;
    logic [ksmx_pkg::MARK_W-1:0] op_mark_reg, op_mark_next;
    logic [IW-1:0]               rd_idx_reg, rd_idx_next;
    logic [IW-1:0]               pos_reg, pos_next;
    logic [ksmx_pkg::KEY_W-1:0]  best_key_reg, best_key_next;
    logic [ksmx_pkg::MARK_W-1:0] best_mark_reg, best_mark_next;
    logic [ksmx_pkg::STAT_W-1:0] status_reg, status_next;
    logic [ksmx_pkg::KEY_W-1:0]  okey_reg, okey_next;
    logic [ksmx_pkg::MARK_W-1:0] omark_reg, omark_next;
    logic [ksmx_pkg::SLOT_W-1:0] oslot_reg, oslot_next;

    logic                        ram_we;
    logic [IW-1:0]               ram_raddr;
    logic [DW-1:0]               ram_wdata;
    logic [DW-1:0]               ram_rdata;

    logic [ksmx_pkg::KEY_W-1:0]  cur_key;
    logic [ksmx_pkg::MARK_W-1:0] cur_mark;
    logic                        cur_v;
    logic                        hit;
    logic                        better;
    logic [IW+ksmx_pkg::SLOT_W-1:0] pos_wide;

    ksmx_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_key   = ram_rdata[DW-1:ksmx_pkg::MARK_W];
    assign cur_mark  = ram_rdata[ksmx_pkg::MARK_W-1:0];
    assign cur_v     = valid_reg[rd_idx_reg];
    assign ram_raddr = addr_reg[IW-1:0];
    assign ram_wdata = {op_key_reg, op_mark_reg};
    assign pos_wide  = {{ksmx_pkg::SLOT_W{1'b0}}, pos_reg};

    assign hit = rd_vld_reg &&
                 (((op_reg == ksmx_pkg::FN_INSERT) && !cur_v) ||
                  ((op_reg == ksmx_pkg::FN_REMOVE) && cur_v && (cur_key == op_key_reg)));

    // strictly better keeps the earliest slot on ties; extract only
    assign better = rd_vld_reg && cur_v &&
                    ((op_reg == ksmx_pkg::FN_HIGHEST) || (op_reg == ksmx_pkg::FN_LOWEST)) &&
                    (!found_reg ||
                     ((op_reg == ksmx_pkg::FN_HIGHEST) && (cur_mark > best_mark_reg)) ||
                     ((op_reg == ksmx_pkg::FN_LOWEST) && (cur_mark < best_mark_reg)));

    assign sts.needs_scan = (func == ksmx_pkg::FN_INSERT)  || (func == ksmx_pkg::FN_REMOVE) ||
                            (func == ksmx_pkg::FN_HIGHEST) || (func == ksmx_pkg::FN_LOWEST);
    assign sts.hit        = hit;
    assign sts.scan_end   = (addr_reg >= n_reg) && !rd_vld_reg;

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_key   = okey_reg;
    assign out_mark  = omark_reg;
    assign out_slot  = oslot_reg;

    always_comb
    begin
        cfg_next       = cfg_reg;
        valid_next     = valid_reg;
        addr_next      = addr_reg;
        n_next         = n_reg;
        rd_vld_next    = rd_vld_reg;
        found_next     = found_reg;
        done_next      = cmd.finish;
        op_next        = op_reg;
        op_key_next    = op_key_reg;
        op_mark_next   = op_mark_reg;
        rd_idx_next    = rd_idx_reg;
        pos_next       = pos_reg;
        best_key_next  = best_key_reg;
        best_mark_next = best_mark_reg;
        status_next    = status_reg;
        okey_next      = okey_reg;
        omark_next     = omark_reg;
        oslot_next     = oslot_reg;
        ram_we         = 1'b0;

        if (cfg_valid)
        begin
            cfg_next = cfg_data;
        end

        if (cmd.load)
        begin
            op_next      = func;
            op_key_next  = entry_key;
            op_mark_next = (entry_mark > ksmx_pkg::MARK_MAX) ? ksmx_pkg::MARK_MAX : entry_mark;
            addr_next    = '0;
            rd_vld_next  = 1'b0;
            found_next   = 1'b0;
            if (int'(cfg_reg) > DEPTH)
            begin
                n_next = CW'(DEPTH);
            end
            else
            begin
                n_next = CW'(cfg_reg);
            end
        end

        if (cmd.scan)
        begin
            // read issue; data is compared in the following cycle
            if (addr_reg < n_reg)
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = addr_reg[IW-1:0];
                addr_next   = addr_reg + 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
            if (hit || better)
            begin
                found_next     = 1'b1;
                pos_next       = rd_idx_reg;
                best_key_next  = cur_key;
                best_mark_next = cur_mark;
            end
        end

        if (cmd.finish)
        begin
            status_next = ksmx_pkg::ST_OK;
            okey_next   = '0;
            omark_next  = '0;
            oslot_next  = '0;
            case (op_reg)
                ksmx_pkg::FN_INSERT:
                begin
                    if (found_reg)
                    begin
                        ram_we              = 1'b1;
                        valid_next[pos_reg] = 1'b1;
                        okey_next           = op_key_reg;
                        omark_next          = op_mark_reg;
                        oslot_next          = pos_wide[ksmx_pkg::SLOT_W-1:0];
                    end
                    else
                    begin
                        status_next = ksmx_pkg::ST_FULL;
                    end
                end
                ksmx_pkg::FN_REMOVE, ksmx_pkg::FN_HIGHEST, ksmx_pkg::FN_LOWEST:
                begin
                    if (found_reg)
                    begin
                        valid_next[pos_reg] = 1'b0;
                        okey_next           = best_key_reg;
                        omark_next          = best_mark_reg;
                        oslot_next          = pos_wide[ksmx_pkg::SLOT_W-1:0];
                    end
                    else
                    begin
                        status_next = ksmx_pkg::ST_NONE;
                    end
                end
                ksmx_pkg::FN_CLEAR:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    status_next = ksmx_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= ksmx_pkg::CFG_W'(16);
            valid_reg  <= '0;
            addr_reg   <= '0;
            n_reg      <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            valid_reg  <= valid_next;
            addr_reg   <= addr_next;
            n_reg      <= n_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        op_key_reg    <= op_key_next;
        op_mark_reg   <= op_mark_next;
        rd_idx_reg    <= rd_idx_next;
        pos_reg       <= pos_next;
        best_key_reg  <= best_key_next;
        best_mark_reg <= best_mark_next;
        status_reg    <= status_next;
        okey_reg      <= okey_next;
        omark_reg     <= omark_next;
        oslot_reg     <= oslot_next;
    end

endmodule
